[hdl/assert_macros.svh]
// Assertion macros shared by the IQ pair assembler RTL.
// Each macro samples on clk_i; the reset-aware form disables on rst_ni low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clk_i edge while rst_ni is high.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every rising clk_i edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

[hdl/iqpa_pkg.sv]
// Shared types and constants for the IQ pair assembler.
// Used by iqpa_scale, iqpa_pair and the top level; no dependencies.
package iqpa_pkg;

  localparam int CODE_BITS_DEF  = 24;
  localparam int COUNT_BITS_DEF = 32;

  localparam int WORD_W  = 32;
  localparam int VAL_W   = 31;
  localparam int TOTAL_W = 32;
  localparam int GAIN_W  = 3;
  localparam int CHAN_W  = 4;
  localparam int PREV_W  = 5;
  localparam int CODE_LSB = 8;

  // Stream data widths, rounded up to whole bytes.
  localparam int S_TDATA_W = 40;
  localparam int M_TDATA_W = 96;

  localparam logic [PREV_W-1:0] NO_CHANNEL = PREV_W'(16);
  localparam logic [CHAN_W-1:0] CH_I       = CHAN_W'(0);
  localparam logic [CHAN_W-1:0] CH_Q       = CHAN_W'(1);

  typedef enum logic {
    ACT_DATA     = 1'b0,
    ACT_DEADLINE = 1'b1
  } action_e;

  typedef logic signed [VAL_W-1:0] val_t;

  // Result of one step, handed from the pairing logic to the output register.
  typedef struct packed {
    logic                  has;
    logic                  timed_out;
    val_t                  i_value;
    val_t                  q_value;
    logic [TOTAL_W-1:0]    timeout_total;
  } pair_res_t;

endpackage

[hdl/iqpa_scale.sv]
// Code scaler: offset-binary ADC code to signed voltage in Vref/2^30 units.
// Depends on iqpa_pkg.
module iqpa_scale import iqpa_pkg::*; #(
  parameter int CODE_BITS = CODE_BITS_DEF
) (
  input  logic [WORD_W-1:0] data_word_i,
  input  logic [GAIN_W-1:0] gain_log2_i,
  output val_t              value_o
);

  localparam int BaseShift = VAL_W - CODE_BITS;

  logic        [CODE_BITS-1:0] code;
  logic signed [CODE_BITS-1:0] diff;
  logic        [4:0]           shift;
  val_t                        ext;

  assign code  = data_word_i[CODE_LSB +: CODE_BITS];
  // code minus half scale: flip the top bit
  assign diff  = {~code[CODE_BITS-1], code[CODE_BITS-2:0]};
  assign ext   = VAL_W'(diff);
  assign shift = 5'(BaseShift) - 5'(gain_log2_i);
  assign value_o = ext <<< shift;

endmodule

[hdl/iqpa_pair.sv]
// Pairing state: channel tracking, pending and last good values, timeout count.
// Depends on iqpa_pkg, iqpa_scale and assert_macros.svh.
`include "assert_macros.svh"

module iqpa_pair import iqpa_pkg::*; #(
  parameter int CODE_BITS  = CODE_BITS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic              action_i,
  input  logic [WORD_W-1:0] data_word_i,
  input  logic              dedup_enable_i,
  input  logic [GAIN_W-1:0] gain_log2_i,
  output pair_res_t         res_o
);

  logic [PREV_W-1:0]     prev_ch_q, prev_ch_d;
  logic                  i_cap_q, i_cap_d, q_cap_q, q_cap_d;
  val_t                  i_pend_q, i_pend_d, q_pend_q, q_pend_d;
  val_t                  good_i_q, good_i_d, good_q_q, good_q_d;
  logic [COUNT_BITS-1:0] cnt_q, cnt_d;
  logic [CHAN_W-1:0]     ch;
  val_t                  scaled;
  logic [TOTAL_W-1:0]    total;
  logic                  res_has;
  logic                  res_timed_out;
  val_t                  res_i;
  val_t                  res_q;

  iqpa_scale #(.CODE_BITS(CODE_BITS)) u_scale (
    .data_word_i (data_word_i),
    .gain_log2_i (gain_log2_i),
    .value_o     (scaled)
  );

  assign ch = data_word_i[CHAN_W-1:0];

  always_comb begin
    prev_ch_d = prev_ch_q;
    i_cap_d   = i_cap_q;
    q_cap_d   = q_cap_q;
    i_pend_d  = i_pend_q;
    q_pend_d  = q_pend_q;
    good_i_d  = good_i_q;
    good_q_d  = good_q_q;
    cnt_d     = cnt_q;
    res_has       = 1'b0;
    res_timed_out = 1'b0;
    res_i         = i_pend_q;
    res_q         = q_pend_q;
    if (action_e'(action_i) == ACT_DEADLINE) begin
      res_has       = 1'b1;
      res_timed_out = 1'b1;
      res_i         = i_cap_q ? i_pend_q : good_i_q;
      res_q         = q_cap_q ? q_pend_q : good_q_q;
      cnt_d   = (cnt_q == '1) ? cnt_q : cnt_q + 1'b1;
      i_cap_d = 1'b0;
      q_cap_d = 1'b0;
    end else if (!(dedup_enable_i && ({1'b0, ch} == prev_ch_q))) begin
      prev_ch_d = {1'b0, ch};
      if (ch == CH_I) begin
        i_pend_d = scaled;
        i_cap_d  = 1'b1;
      end else if (ch == CH_Q) begin
        q_pend_d = scaled;
        q_cap_d  = 1'b1;
      end
      if (i_cap_d && q_cap_d) begin
        res_has  = 1'b1;
        res_i    = i_pend_d;
        res_q    = q_pend_d;
        good_i_d = i_pend_d;
        good_q_d = q_pend_d;
        i_cap_d  = 1'b0;
        q_cap_d  = 1'b0;
      end
    end
  end

  // Report the count after this step, clamped to the result field.
  if (COUNT_BITS > TOTAL_W) begin : g_clamp
    assign total = (|cnt_d[COUNT_BITS-1:TOTAL_W]) ? '1 : cnt_d[TOTAL_W-1:0];
  end else begin : g_extend
    assign total = TOTAL_W'(cnt_d);
  end

  assign res_o = {res_has, res_timed_out, res_i, res_q, total};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_ch_q <= NO_CHANNEL;
      i_cap_q   <= 1'b0;
      q_cap_q   <= 1'b0;
      i_pend_q  <= '0;
      q_pend_q  <= '0;
      good_i_q  <= '0;
      good_q_q  <= '0;
      cnt_q     <= '0;
    end else if (step_i) begin
      prev_ch_q <= prev_ch_d;
      i_cap_q   <= i_cap_d;
      q_cap_q   <= q_cap_d;
      i_pend_q  <= i_pend_d;
      q_pend_q  <= q_pend_d;
      good_i_q  <= good_i_d;
      good_q_q  <= good_q_d;
      cnt_q     <= cnt_d;
    end
  end

  `ASSERT_ALWAYS(a_caps_not_both, !(i_cap_q && q_cap_q), "both channels held after a step")
  `ASSERT_CLK(a_cnt_monotonic, 1'b1 |=> cnt_q >= $past(cnt_q), "timeout count went down")
  `ASSERT_CLK(a_timeout_counted, res_o.has && res_o.timed_out |-> res_o.timeout_total != '0,
              "deadline result with zero timeout total")

endmodule

[hdl/iq_pair_assembler_with_timeout.sv]
// Top level of the IQ pair assembler: input stage, pairing logic, output register.
// Depends on iqpa_pkg, iqpa_pair and assert_macros.svh.
`include "assert_macros.svh"

// Takes one stream word per cycle unless a waiting pair stalls it, and returns at most one IQ pair per word.
// A word passes through an input register, is decided combinationally against
// the pairing state, and its result lands in the output register, which drives
// m_axis_tvalid; one word per cycle is sustained while m_axis_tready stays high;
// a word that yields no pair still advances while a finished pair waits, and a
// word that yields a pair holds s_axis_tready low until the waiting pair is
// taken.
// s_axis_tdata carries data_word in [31:0] and dedup_enable in [32];
// s_axis_tuser is the action (0 data word, 1 pair deadline). m_axis_tdata
// carries i_value [30:0], q_value [61:31] and timeout_total [93:62];
// m_axis_tuser is timed_out.
// Write gain_log2 through the cfg channel only while the block is idle.
module iq_pair_assembler_with_timeout import iqpa_pkg::*; #(
  parameter int CODE_BITS  = CODE_BITS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // cfg_data_i: gain_log2 [2:0]
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [GAIN_W-1:0]    cfg_data_i,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // s_axis_tdata: data_word [31:0], dedup_enable [32], zero fill [39:33]
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  // s_axis_tuser: action [0]
  input  logic                 s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // m_axis_tdata: i_value [30:0], q_value [61:31], timeout_total [93:62], zero fill [95:94]
  output logic [M_TDATA_W-1:0] m_axis_tdata,
  // m_axis_tuser: timed_out [0]
  output logic                 m_axis_tuser
);

  logic              cfg_fire;
  logic [GAIN_W-1:0] gain_log2_q;
  logic              in_valid_q;
  logic              in_action_q;
  logic [WORD_W-1:0] in_word_q;
  logic              in_dedup_q;
  logic              fire;
  logic              out_valid_q;
  pair_res_t         res;
  pair_res_t         out_q;

  assign cfg_fire = cfg_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_log2_q <= '0;
    end else if (cfg_fire) begin
      gain_log2_q <= cfg_data_i;
    end
  end

  assign cfg_ready_o = 1'b1;

  iqpa_pair #(
    .CODE_BITS  (CODE_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_pair (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (fire),
    .action_i       (in_action_q),
    .data_word_i    (in_word_q),
    .dedup_enable_i (in_dedup_q),
    .gain_log2_i    (gain_log2_q),
    .res_o          (res)
  );

  // Advance the held word unless its result would overwrite a waiting pair.
  assign fire = in_valid_q && (!res.has || !out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (fire && res.has) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_action_q <= s_axis_tuser;
      in_word_q   <= s_axis_tdata[WORD_W-1:0];
      in_dedup_q  <= s_axis_tdata[WORD_W];
    end
    if (fire && res.has) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.timed_out;
  assign m_axis_tdata  = {2'b00, out_q.timeout_total, out_q.q_value, out_q.i_value};

  `ASSERT_CLK(a_out_from_step, $rose(m_axis_tvalid) |-> $past(fire),
              "result appeared without a processed word")
  `ASSERT_CLK(a_wait_holds_word, in_valid_q && !fire |=> in_valid_q,
              "held word lost while the output was stalled")
  `ASSERT_CLK(a_out_stable, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser),
              "waiting pair changed before it was taken")

endmodule

[test/tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for iq_pair_assembler_with_timeout: stream stimulus, IQ pair prediction.
// Depends on iqpa_pkg and the iq_pair_assembler_with_timeout RTL.
module tb;
  import iqpa_pkg::*;

  localparam int CODE_W       = CODE_BITS_DEF;
  localparam int CYCLE_LIMIT  = 200_000;
  localparam int DRAIN_CYCLES = 8;
  localparam int BLOCK_WORDS  = 80;

  typedef struct packed {
    val_t               i_value;
    val_t               q_value;
    logic               timed_out;
    logic [TOTAL_W-1:0] timeout_total;
  } iq_pair_t;

  // Tracks the pairing state and the pairs still owed by the block.
  class pair_tracker;
    logic [GAIN_W-1:0]  gain;
    logic [PREV_W-1:0]  prev_chan;
    bit                 i_held, q_held;
    val_t               i_hold, q_hold, good_i, good_q;
    logic [TOTAL_W-1:0] deadline_count;
    iq_pair_t           pairs_due[$];
    int unsigned        errors;

    function new();
      gain = '0;
      prev_chan = NO_CHANNEL;
      i_held = 1'b0;
      q_held = 1'b0;
      i_hold = '0;
      q_hold = '0;
      good_i = '0;
      good_q = '0;
      deadline_count = '0;
      errors = 0;
    endfunction

    function void set_gain(logic [GAIN_W-1:0] g);
      gain = g;
    endfunction

    function int pending();
      return pairs_due.size();
    endfunction

    function void flag(string what);
      errors++;
      if (errors <= 10) $display("mismatch: %s", what);
    endfunction

    // Center the offset-binary code, then scale to Vref/2^30 units.
    function val_t to_volts(logic [WORD_W-1:0] word);
      logic signed [CODE_W-1:0] centered;
      val_t widened;
      int   sh;
      centered = word[CODE_LSB +: CODE_W] - CODE_W'(1 << (CODE_W - 1));
      widened = {{(VAL_W - CODE_W){centered[CODE_W-1]}}, centered};
      sh = VAL_W - CODE_W - int'(gain);
      return widened <<< sh;
    endfunction

    // Returns 0 when the word is dropped as a repeated channel.
    function bit accept_word(action_e act, logic [WORD_W-1:0] word, logic dedup);
      logic [PREV_W-1:0] chan;
      iq_pair_t pair;
      if (act == ACT_DEADLINE) begin
        if (deadline_count != '1) deadline_count++;
        pair = '{i_held ? i_hold : good_i, q_held ? q_hold : good_q, 1'b1, deadline_count};
        pairs_due.push_back(pair);
        i_held = 1'b0;
        q_held = 1'b0;
        return 1'b1;
      end
      chan = {1'b0, word[CHAN_W-1:0]};
      if (dedup && chan == prev_chan) return 1'b0;
      prev_chan = chan;
      if (chan == {1'b0, CH_I}) begin
        i_hold = to_volts(word);
        i_held = 1'b1;
      end else if (chan == {1'b0, CH_Q}) begin
        q_hold = to_volts(word);
        q_held = 1'b1;
      end
      if (i_held && q_held) begin
        good_i = i_hold;
        good_q = q_hold;
        i_held = 1'b0;
        q_held = 1'b0;
        pair = '{i_hold, q_hold, 1'b0, deadline_count};
        pairs_due.push_back(pair);
      end
      return 1'b1;
    endfunction

    function void check_pair(logic [M_TDATA_W-1:0] tdata, logic tuser);
      iq_pair_t want;
      val_t got_i, got_q;
      logic [TOTAL_W-1:0] got_total;
      got_i = tdata[VAL_W-1:0];
      got_q = tdata[2*VAL_W-1:VAL_W];
      got_total = tdata[2*VAL_W +: TOTAL_W];
      if (pairs_due.size() == 0) begin
        flag($sformatf("unexpected pair i=%0d q=%0d timed_out=%0b total=%0d",
                       got_i, got_q, tuser, got_total));
        return;
      end
      want = pairs_due.pop_front();
      if (got_i !== want.i_value)
        flag($sformatf("i_value expected %0d got %0d", want.i_value, got_i));
      if (got_q !== want.q_value)
        flag($sformatf("q_value expected %0d got %0d", want.q_value, got_q));
      if (tuser !== want.timed_out)
        flag($sformatf("timed_out expected %0b got %0b", want.timed_out, tuser));
      if (got_total !== want.timeout_total)
        flag($sformatf("timeout_total expected %0d got %0d", want.timeout_total, got_total));
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [GAIN_W-1:0]    cfg_data_i = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata = '0;
  logic                 s_axis_tuser = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic                 m_axis_tuser;

  pair_tracker tracker = new();
  int          src_idle_pct = 38;
  int          sink_idle_pct = 71;
  int unsigned cycles = 0;
  logic [CHAN_W-1:0] last_chan = CH_Q;

  iq_pair_assembler_with_timeout dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("iq_pair_assembler_with_timeout test failed");
      $finish;
    end
  end

  // Take pairs off the output and randomize the back-pressure for the next edge.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      tracker.check_pair(m_axis_tdata, m_axis_tuser);
    m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
  end

  task automatic send_item(input action_e act, input logic [WORD_W-1:0] word,
                           input logic dedup, output bit taken);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(S_TDATA_W - WORD_W - 1){1'b0}}, dedup, word};
    s_axis_tuser  <= act;
    do @(posedge clk_i); while (!s_axis_tready);
    taken = tracker.accept_word(act, word, dedup);
  endtask

  // Drop valid, wait for every owed pair, then let words without a result flush out.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_gain(input logic [GAIN_W-1:0] g);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= g;
    do @(posedge clk_i); while (!cfg_ready_o);
    tracker.set_gain(g);
    cfg_valid_i <= 1'b0;
  endtask

  // Mostly alternating I/Q words with random codes; repeats, stray channels
  // and deadlines break up the pairs.
  task automatic random_block(input int words);
    int                taken_count;
    int                r;
    bit                taken;
    logic [CHAN_W-1:0] ch;
    logic [CODE_W-1:0] code;
    logic [3:0]        mid;
    taken_count = 0;
    while (taken_count < words) begin
      if ($urandom_range(99) < 12) begin
        send_item(ACT_DEADLINE, $urandom(), 1'($urandom_range(1)), taken);
      end else begin
        r = $urandom_range(99);
        if (r < 75) ch = (last_chan == CH_I) ? CH_Q : CH_I;
        else if (r < 90) ch = last_chan;
        else ch = CHAN_W'($urandom_range(15));
        if ($urandom_range(9) == 0) begin
          case ($urandom_range(3))
            0: code = '0;
            1: code = '1;
            2: code = CODE_W'(1 << (CODE_W - 1));
            default: code = CODE_W'((1 << (CODE_W - 1)) - 1);
          endcase
        end else begin
          code = CODE_W'($urandom());
        end
        mid = 4'($urandom_range(15));
        last_chan = ch;
        send_item(ACT_DATA, {code, mid, ch}, 1'($urandom_range(1)), taken);
      end
      if (taken) taken_count++;
    end
  endtask

  initial begin
    bit          taken;
    int unsigned gain_plan[6];
    gain_plan = '{7, 0, 3, 5, 0, 7};
    gain_plan[2] = $urandom_range(1, 6);
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    write_gain(GAIN_W'(0));
    send_item(ACT_DEADLINE, 32'h0000_0000, 1'b0, taken);            // nothing held yet
    send_item(ACT_DATA, {24'h000000, 4'h0, CH_I}, 1'b0, taken);     // most negative
    send_item(ACT_DATA, {24'hFFFFFF, 4'hF, CH_Q}, 1'b1, taken);     // most positive
    send_item(ACT_DATA, {24'h800000, 4'h5, CH_Q}, 1'b0, taken);     // Q before I
    send_item(ACT_DATA, {24'h7FFFFF, 4'hA, CH_I}, 1'b0, taken);
    send_item(ACT_DATA, {24'h123456, 4'h0, CH_I}, 1'b0, taken);     // replaced by next
    send_item(ACT_DATA, {24'hFEDCBA, 4'h0, CH_I}, 1'b0, taken);
    send_item(ACT_DATA, {24'h00ABCD, 4'h0, CH_Q}, 1'b0, taken);
    send_item(ACT_DATA, {24'h3C3C3C, 4'h0, CH_Q}, 1'b0, taken);
    send_item(ACT_DATA, {24'hC3C3C3, 4'h0, CH_Q}, 1'b1, taken);     // repeat, dropped
    send_item(ACT_DATA, {24'h555555, 4'h0, CH_I}, 1'b1, taken);
    send_item(ACT_DATA, 32'hFFFF_FF05, 1'b0, taken);                // stray channel
    send_item(ACT_DATA, 32'hFFFF_FFFF, 1'b1, taken);
    send_item(ACT_DATA, 32'hFFFF_FFFF, 1'b1, taken);                // repeat, dropped
    send_item(ACT_DATA, {24'hAAAAAA, 4'h0, CH_I}, 1'b1, taken);
    send_item(ACT_DEADLINE, 32'hFFFF_FFFF, 1'b1, taken);            // stale Q
    send_item(ACT_DATA, {24'h0F0F0F, 4'hF, CH_Q}, 1'b0, taken);
    send_item(ACT_DEADLINE, 32'h0000_0000, 1'b0, taken);            // stale I
    send_item(ACT_DEADLINE, 32'h0000_0000, 1'b0, taken);            // both stale
    // deadline leaves the channel history alone, so this repeat is dropped
    send_item(ACT_DATA, {24'hF0F0F0, 4'h0, CH_Q}, 1'b1, taken);
    send_item(ACT_DATA, {24'h000001, 4'h0, CH_I}, 1'b1, taken);
    send_item(ACT_DATA, {24'hFFFFFE, 4'h0, CH_Q}, 1'b1, taken);
    drain();
    write_gain(GAIN_W'(7));
    send_item(ACT_DATA, {24'h000000, 4'h0, CH_I}, 1'b0, taken);
    send_item(ACT_DATA, {24'hFFFFFF, 4'h0, CH_Q}, 1'b0, taken);
    send_item(ACT_DEADLINE, 32'h0000_0000, 1'b0, taken);

    for (int p = 0; p < 6; p++) begin
      drain();
      if (p == 2) begin
        src_idle_pct = 71;
        sink_idle_pct = 38;
      end else if (p == 4) begin
        src_idle_pct = 0;
        sink_idle_pct = 0;
      end
      write_gain(GAIN_W'(gain_plan[p]));
      random_block(BLOCK_WORDS);
    end
    drain();

    if (tracker.errors == 0)
      $display("iq_pair_assembler_with_timeout test passed");
    else
      $display("iq_pair_assembler_with_timeout test failed");
    $finish;
  end

endmodule

[iq_pair_assembler_with_timeout.f]
+incdir+hdl
hdl/iqpa_pkg.sv
hdl/iqpa_scale.sv
hdl/iqpa_pair.sv
hdl/iq_pair_assembler_with_timeout.sv
test/tb.sv
